// File: rtl/bmp_pkg.sv
`timescale 1ns / 1ps

package bmp_pkg;

   // Modulus and result width
   localparam int unsigned VALUE_W        = 30;
   localparam logic [VALUE_W-1:0] PRIME   = 30'd998244353;
   localparam int unsigned MAX_N_BITS_DEF = 20;

   // Barrett constant floor(2^60 / p), below 2^31
   localparam int unsigned MU_W = 31;
   localparam logic [MU_W-1:0] BARRETT_MU = MU_W'((64'd1 << 60) / 64'(PRIME));

   // Fermat exponent p - 2, walked from its LSB
   localparam int unsigned EXP_W = 30;
   localparam logic [EXP_W-1:0] INV_EXPONENT = PRIME - 30'd2;
   localparam int unsigned BIT_W = 5;
   localparam logic [BIT_W-1:0] EXP_LAST_BIT = BIT_W'(EXP_W - 1);

   // Sequencer program addresses
   localparam int unsigned PC_W = 5;
   localparam logic [PC_W-1:0] ST_IDLE     = 5'd0;
   localparam logic [PC_W-1:0] ST_SETUP    = 5'd1;
   localparam logic [PC_W-1:0] ST_LOOP     = 5'd2;
   localparam logic [PC_W-1:0] ST_MUL_DEN  = 5'd3;
   localparam logic [PC_W-1:0] ST_WAIT_I0  = 5'd4;
   localparam logic [PC_W-1:0] ST_WAIT_I1  = 5'd5;
   localparam logic [PC_W-1:0] ST_WB_NUM   = 5'd6;
   localparam logic [PC_W-1:0] ST_WB_DEN   = 5'd7;
   localparam logic [PC_W-1:0] ST_INV      = 5'd8;
   localparam logic [PC_W-1:0] ST_EXP_MUL  = 5'd9;
   localparam logic [PC_W-1:0] ST_EXP_SQR  = 5'd10;
   localparam logic [PC_W-1:0] ST_WAIT_E0  = 5'd11;
   localparam logic [PC_W-1:0] ST_WAIT_E1  = 5'd12;
   localparam logic [PC_W-1:0] ST_WB_ACC   = 5'd13;
   localparam logic [PC_W-1:0] ST_WB_BASE  = 5'd14;
   localparam logic [PC_W-1:0] ST_FINAL    = 5'd15;
   localparam logic [PC_W-1:0] ST_WAIT_F0  = 5'd16;
   localparam logic [PC_W-1:0] ST_WAIT_F1  = 5'd17;
   localparam logic [PC_W-1:0] ST_WAIT_F2  = 5'd18;
   localparam logic [PC_W-1:0] ST_WB_RES   = 5'd19;
   localparam logic [PC_W-1:0] ST_OUT      = 5'd20;
   localparam logic [PC_W-1:0] ST_RETURN   = 5'd21;

   typedef enum logic [1:0] {
      SEL_A_NUM,
      SEL_A_DEN,
      SEL_A_ACC,
      SEL_A_BASE
   } sel_a_type;

   typedef enum logic [1:0] {
      SEL_B_IDX,
      SEL_B_IDX_R,
      SEL_B_BASE,
      SEL_B_ACC
   } sel_b_type;

   typedef enum logic [2:0] {
      WR_NONE,
      WR_NUM,
      WR_DEN,
      WR_ACC_IF_BIT,
      WR_BASE,
      WR_RES
   } wr_type;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_IDLE,
      ACT_SETUP,
      ACT_STEP_I,
      ACT_INV_INIT,
      ACT_STEP_BIT,
      ACT_OUT
   } act_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_INVALID,
      COND_I_DONE,
      COND_MORE_BITS,
      COND_RSP_WAIT
   } cond_type;

   typedef struct packed {
      sel_a_type        sel_a;
      sel_b_type        sel_b;
      wr_type           wr;
      act_type          act;
      cond_type         cond;
      logic [PC_W-1:0]  target;
   } ucode_word_type;

   // Control store. An operand pair issued at one step is written back by a later step's write
   // field, once the product leaves the last register of the multiplier pipeline.
   function automatic ucode_word_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_word_type w;
      w = '{sel_a: SEL_A_NUM, sel_b: SEL_B_IDX, wr: WR_NONE, act: ACT_NONE,
            cond: COND_NONE, target: ST_IDLE};
      case (pc)
         ST_IDLE: begin
            w.act = ACT_IDLE; w.cond = COND_NO_REQ; w.target = ST_IDLE;
         end
         ST_SETUP: begin
            w.act = ACT_SETUP; w.cond = COND_INVALID; w.target = ST_OUT;
         end
         ST_LOOP: begin
            w.sel_a = SEL_A_NUM; w.sel_b = SEL_B_IDX;
            w.cond = COND_I_DONE; w.target = ST_INV;
         end
         ST_MUL_DEN: begin
            w.sel_a = SEL_A_DEN; w.sel_b = SEL_B_IDX_R; w.act = ACT_STEP_I;
         end
         ST_WAIT_I0, ST_WAIT_I1: begin
         end
         ST_WB_NUM: begin
            w.wr = WR_NUM;
         end
         ST_WB_DEN: begin
            w.wr = WR_DEN; w.cond = COND_ALWAYS; w.target = ST_LOOP;
         end
         ST_INV: begin
            w.act = ACT_INV_INIT;
         end
         ST_EXP_MUL: begin
            w.sel_a = SEL_A_ACC; w.sel_b = SEL_B_BASE;
         end
         ST_EXP_SQR: begin
            w.sel_a = SEL_A_BASE; w.sel_b = SEL_B_BASE;
         end
         ST_WAIT_E0, ST_WAIT_E1: begin
         end
         ST_WB_ACC: begin
            w.wr = WR_ACC_IF_BIT;
         end
         ST_WB_BASE: begin
            w.wr = WR_BASE; w.act = ACT_STEP_BIT;
            w.cond = COND_MORE_BITS; w.target = ST_EXP_MUL;
         end
         ST_FINAL: begin
            w.sel_a = SEL_A_NUM; w.sel_b = SEL_B_ACC;
         end
         ST_WAIT_F0, ST_WAIT_F1, ST_WAIT_F2: begin
         end
         ST_WB_RES: begin
            w.wr = WR_RES;
         end
         ST_OUT: begin
            w.act = ACT_OUT; w.cond = COND_RSP_WAIT; w.target = ST_OUT;
         end
         ST_RETURN: begin
            w.cond = COND_ALWAYS; w.target = ST_IDLE;
         end
         default: begin
            w.cond = COND_ALWAYS; w.target = ST_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

// File: rtl/bmp_chan_if.sv
`timescale 1ns / 1ps

interface bmp_req_if import bmp_pkg::*; #(
   parameter int unsigned MAX_N_BITS = MAX_N_BITS_DEF
);
   logic                    valid;
   logic                    ready;
   logic [MAX_N_BITS-1:0]   total_count;
   logic signed [MAX_N_BITS:0] choose_count;

   modport source (output valid, output total_count, output choose_count, input ready);
   modport sink   (input valid, input total_count, input choose_count, output ready);
endinterface

interface bmp_rsp_if import bmp_pkg::*;;
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] binomial_value;

   modport source (output valid, output binomial_value, input ready);
   modport sink   (input valid, input binomial_value, output ready);
endinterface

// File: rtl/bmp_modmul.sv
`timescale 1ns / 1ps

module bmp_modmul import bmp_pkg::*; (
   input  logic               clock,
   input  logic [VALUE_W-1:0] a,
   input  logic [VALUE_W-1:0] b,
   output logic [VALUE_W-1:0] product
);

   // Four-stage Barrett pipeline, one operand pair per cycle.
   logic [59:0] s1_prod_ff;
   logic [30:0] s2_q_ff;
   logic [31:0] s2_lo_ff;
   logic [31:0] s3_qp_ff;
   logic [31:0] s3_lo_ff;
   logic [VALUE_W-1:0] s4_out_ff;

   logic [59:0] s1_prod_in;
   logic [61:0] s2_full;
   logic [60:0] s3_full;
   logic [31:0] s4_rem;
   logic [VALUE_W-1:0] s4_out_in;

   assign s1_prod_in = {30'd0, a} * {30'd0, b};
   assign s2_full    = {31'd0, s1_prod_ff[59:29]} * {31'd0, BARRETT_MU};
   assign s3_full    = {30'd0, s2_q_ff} * {31'd0, PRIME};

   // Estimate is short by at most two multiples of p
   always_comb begin
      s4_rem = s3_lo_ff - s3_qp_ff;
      if (s4_rem >= {PRIME, 1'b0}) begin
         s4_out_in = VALUE_W'(s4_rem - {PRIME, 1'b0});
      end else if (s4_rem >= {2'd0, PRIME}) begin
         s4_out_in = VALUE_W'(s4_rem - {2'd0, PRIME});
      end else begin
         s4_out_in = VALUE_W'(s4_rem);
      end
   end

   always_ff @(posedge clock) begin
      s1_prod_ff <= s1_prod_in;
      s2_q_ff    <= s2_full[61:31];
      s2_lo_ff   <= s1_prod_ff[31:0];
      s3_qp_ff   <= s3_full[31:0];
      s3_lo_ff   <= s2_lo_ff;
      s4_out_ff  <= s4_out_in;
   end

   assign product = s4_out_ff;

endmodule

// File: rtl/binomial_mod_prime_unit.sv
`timescale 1ns / 1ps

// Binomial coefficient unit: takes one (total_count = n, choose_count = r) item and returns
// C(n, r) mod 998244353 as one rsp item. A negative r or an r above n yields 0. The unit works
// on one item at a time: req ready is high only while the sequencer idles, and the next item
// is taken once the result has left. An item with r outside 0..n goes from setup straight to
// the output step. Otherwise the sequencer makes k = n - min(r, n - r) loop passes and then one
// pass for each of the 30 exponent bits of the Fermat inverse; each pass issues its two products
// to the single pipelined modular multiplier that every product goes through, then waits for
// their write-back. Control is a 22-word microprogram; there is no state kept between items.
module binomial_mod_prime_unit import bmp_pkg::*; #(
   parameter int unsigned MAX_N_BITS = MAX_N_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   bmp_req_if.sink   req_chan,
   bmp_rsp_if.source rsp_chan
);

   localparam int unsigned NW = MAX_N_BITS;

   // Sequencer
   logic [PC_W-1:0] pc_ff, pc_in;
   ucode_word_type  uw;
   logic            jump;

   // Datapath registers
   logic [NW-1:0]      n_ff, n_in;
   logic [NW-1:0]      r_ff, r_in;
   logic               neg_ff, neg_in;
   logic [NW:0]        i_ff, i_in;
   logic [VALUE_W-1:0] num_ff, num_in;
   logic [VALUE_W-1:0] den_ff, den_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [VALUE_W-1:0] base_ff, base_in;
   logic [VALUE_W-1:0] res_ff, res_in;
   logic [BIT_W-1:0]   bit_ff, bit_in;

   // Datapath signals
   logic               req_fire, rsp_fire;
   logic               invalid, i_done, bit_set, more_bits;
   logic [NW-1:0]      diff, r_fold;
   logic [NW:0]        idx_r;
   logic [VALUE_W-1:0] op_a, op_b, mm_out;

   assign uw       = ucode_rom(pc_ff);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   assign req_chan.ready          = (uw.act == ACT_IDLE);
   assign rsp_chan.valid          = (uw.act == ACT_OUT);
   assign rsp_chan.binomial_value = res_ff;

   // Range check and fold of r to the smaller side
   assign invalid   = neg_ff || (r_ff > n_ff);
   assign diff      = n_ff - r_ff;
   assign r_fold    = (diff < r_ff) ? diff : r_ff;
   assign i_done    = i_ff > {1'b0, n_ff};
   assign idx_r     = i_ff - {1'b0, r_ff};
   assign bit_set   = INV_EXPONENT[bit_ff];
   assign more_bits = (bit_ff != EXP_LAST_BIT);

   // Operand select for the shared multiplier
   always_comb begin
      case (uw.sel_a)
         SEL_A_NUM:  op_a = num_ff;
         SEL_A_DEN:  op_a = den_ff;
         SEL_A_ACC:  op_a = acc_ff;
         SEL_A_BASE: op_a = base_ff;
         default:    op_a = num_ff;
      endcase
      case (uw.sel_b)
         SEL_B_IDX:   op_b = VALUE_W'(i_ff);
         SEL_B_IDX_R: op_b = VALUE_W'(idx_r);
         SEL_B_BASE:  op_b = base_ff;
         SEL_B_ACC:   op_b = acc_ff;
         default:     op_b = base_ff;
      endcase
   end

   bmp_modmul u_modmul (
      .clock   (clock),
      .a       (op_a),
      .b       (op_b),
      .product (mm_out)
   );

   always_comb begin
      n_in    = n_ff;
      r_in    = r_ff;
      neg_in  = neg_ff;
      i_in    = i_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      acc_in  = acc_ff;
      base_in = base_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;

      case (uw.act)
         ACT_IDLE: begin
            // capture the item; sign bit flags a negative r
            if (req_fire) begin
               n_in   = req_chan.total_count;
               r_in   = req_chan.choose_count[NW-1:0];
               neg_in = req_chan.choose_count[NW];
            end
         end
         ACT_SETUP: begin
            r_in   = r_fold;
            i_in   = {1'b0, r_fold} + 1'b1;
            num_in = VALUE_W'(1);
            den_in = VALUE_W'(1);
            res_in = '0;
         end
         ACT_STEP_I: begin
            i_in = i_ff + 1'b1;
         end
         ACT_INV_INIT: begin
            acc_in  = VALUE_W'(1);
            base_in = den_ff;
            bit_in  = '0;
         end
         ACT_STEP_BIT: begin
            bit_in = bit_ff + 1'b1;
         end
         ACT_NONE, ACT_OUT: begin
         end
         default: begin
         end
      endcase

      // Write back the product that now leaves the multiplier pipeline
      case (uw.wr)
         WR_NUM:        num_in  = mm_out;
         WR_DEN:        den_in  = mm_out;
         WR_ACC_IF_BIT: if (bit_set) acc_in = mm_out;
         WR_BASE:       base_in = mm_out;
         WR_RES:        res_in  = mm_out;
         WR_NONE:       ;
         default:       ;
      endcase

      case (uw.cond)
         COND_NONE:      jump = 1'b0;
         COND_ALWAYS:    jump = 1'b1;
         COND_NO_REQ:    jump = !req_fire;
         COND_INVALID:   jump = invalid;
         COND_I_DONE:    jump = i_done;
         COND_MORE_BITS: jump = more_bits;
         COND_RSP_WAIT:  jump = !rsp_fire;
         default:        jump = 1'b1;
      endcase

      pc_in = jump ? uw.target : pc_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      r_ff    <= r_in;
      neg_ff  <= neg_in;
      i_ff    <= i_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      acc_ff  <= acc_in;
      base_ff <= base_in;
      res_ff  <= res_in;
      bit_ff  <= bit_in;
   end

   // Only one item in flight: never ready for input while a result is offered
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("input ready while result pending");

   // An accepted item moves the sequencer out of idle at once
   a_leave_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (pc_ff == ST_SETUP))
      else $error("sequencer did not start on accepted item");

   // Every offered result is a reduced residue
   a_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.binomial_value < PRIME))
      else $error("result not reduced mod p");

   // Sequencer stays inside the program
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= ST_RETURN)
      else $error("step counter left the program");

endmodule

// File: tb/binomial_mod_prime_unit_tb.sv
`timescale 1ns / 1ps

module binomial_mod_prime_unit_tb;
   import bmp_pkg::*;

   localparam int unsigned N_W    = MAX_N_BITS_DEF;
   localparam int unsigned N_MAX  = (1 << N_W) - 1;
   localparam int unsigned RANDOM_ITEMS = 100;
   // Last items of the random part run with both sides streaming
   localparam int unsigned CALM_ITEMS   = 20;

   // Track expected binomial values and compare them against the rsp stream
   class binomial_tracker;
      logic [VALUE_W-1:0] expected_values[$];
      int unsigned        mismatch_count;

      function new();
         mismatch_count = 0;
      endfunction

      task report(input string msg);
         $display("[%0t] MISMATCH: %s", $realtime, msg);
         mismatch_count++;
      endtask

      function longint unsigned mod_mul(input longint unsigned a, input longint unsigned b);
         return (a * b) % 64'(PRIME);
      endfunction

      // Compute C(n, r) mod p: fold r, run both products, then Fermat inverse
      function logic [VALUE_W-1:0] predict_binomial(input logic [N_W-1:0] n,
                                                    input logic signed [N_W:0] r);
         longint unsigned num, den, acc, base, expo, r_fold, i, n_val;
         if (r[N_W] || 64'(r[N_W-1:0]) > 64'(n))
            return '0;
         n_val  = 64'(n);
         r_fold = 64'(r[N_W-1:0]);
         if (n_val - r_fold < r_fold)
            r_fold = n_val - r_fold;
         num = 1;
         den = 1;
         for (i = r_fold + 1; i <= n_val; i++) begin
            num = mod_mul(num, i);
            den = mod_mul(den, i - r_fold);
         end
         acc  = 1;
         base = den;
         expo = 64'(PRIME) - 2;
         while (expo != 0) begin
            if (expo[0])
               acc = mod_mul(acc, base);
            base = mod_mul(base, base);
            expo >>= 1;
         end
         return VALUE_W'(mod_mul(num, acc));
      endfunction

      function void note_pair(input logic [N_W-1:0] n, input logic signed [N_W:0] r);
         expected_values.push_back(predict_binomial(n, r));
      endfunction

      task check_value(input logic [VALUE_W-1:0] got);
         logic [VALUE_W-1:0] want;
         if (expected_values.size() == 0) begin
            report($sformatf("binomial_value %0d arrived with nothing pending", got));
         end else begin
            want = expected_values.pop_front();
            if (got !== want)
               report($sformatf("binomial_value got %0d, want %0d", got, want));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   bit   idle_on;

   binomial_tracker tracker;

   bmp_req_if #(.MAX_N_BITS(N_W)) req_chan ();
   bmp_rsp_if                     rsp_chan ();

   binomial_mod_prime_unit #(.MAX_N_BITS(N_W)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Present one (n, r) item and hold it until the block takes it. An optional
   // idle burst goes in front so gaps land on every phase of the sequencer.
   task send_pair(input logic [N_W-1:0] n, input logic signed [N_W:0] r);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.total_count  <= n;
      req_chan.choose_count <= r;
      // Sample ready as it stood before the edge; valid is ours and already high
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      tracker.note_pair(n, r);
   endtask

   // Draw a random r in 0..n, leaning on the two ends now and then
   function automatic logic signed [N_W:0] pick_in_range(input int unsigned n);
      int unsigned pick;
      case ($urandom_range(0, 7))
         0: pick = 0;
         1: pick = n;
         default: pick = $urandom_range(0, n);
      endcase
      return {1'b0, N_W'(pick)};
   endfunction

   // Result side: check every accepted item, then decide ready for the next edge
   initial begin
      int unsigned hold_left;
      hold_left      = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
            tracker.check_value(rsp_chan.binomial_value);
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            // Start a stall that holds ready low, this edge included
            hold_left      = $urandom_range(0, 3);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      int unsigned              n_pick;
      int unsigned              r_pick;
      logic [N_W-1:0]           n_val;
      logic signed [N_W:0]      r_val;

      tracker               = new();
      idle_on               = 1'b1;
      reset                 <= 1'b1;
      req_chan.valid        <= 1'b0;
      req_chan.total_count  <= '0;
      req_chan.choose_count <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty set, both ends of r, out-of-range r on either side,
      // field extremes, folding on both halves, and a few products past the prime
      send_pair(0, 0);
      send_pair(0, -1);
      send_pair(1, 0);
      send_pair(1, 1);
      send_pair(5, 0);
      send_pair(5, 5);
      send_pair(5, 6);
      send_pair(5, 2);
      send_pair(10, 3);
      send_pair(31, 16);
      send_pair(31, 15);
      send_pair(40, 20);
      send_pair(100, -5);
      send_pair(N_W'(N_MAX), {1'b1, {N_W{1'b0}}});
      send_pair(N_W'(N_MAX), -1);
      send_pair(0, {1'b0, {N_W{1'b1}}});
      send_pair(N_W'(N_MAX - 1), {1'b0, {N_W{1'b1}}});
      send_pair(2000, 1999);
      send_pair(3000, 1);
      send_pair(1000, 500);
      // One long item: a deep loop run plus the full inverse
      send_pair(65535, 32767);

      // Random part: mostly small in-range pairs, some medium, the rest out of range
      for (int unsigned item = 0; item < RANDOM_ITEMS; item++) begin
         if (item == RANDOM_ITEMS - CALM_ITEMS)
            idle_on = 1'b0;
         case ($urandom_range(0, 9))
            0: begin
               n_val = N_W'($urandom);
               r_val = {1'b1, N_W'($urandom)};
            end
            1: begin
               n_pick = $urandom_range(0, N_MAX - 1);
               r_pick = $urandom_range(n_pick + 1, N_MAX);
               n_val  = N_W'(n_pick);
               r_val  = {1'b0, N_W'(r_pick)};
            end
            2: begin
               n_pick = $urandom_range(64, 1023);
               n_val  = N_W'(n_pick);
               r_val  = pick_in_range(n_pick);
            end
            default: begin
               n_pick = $urandom_range(0, 63);
               n_val  = N_W'(n_pick);
               r_val  = pick_in_range(n_pick);
            end
         endcase
         send_pair(n_val, r_val);
      end
      req_chan.valid <= 1'b0;

      // Drain pending results, then watch a while for strays
      while (tracker.expected_values.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      if (tracker.mismatch_count == 0 && tracker.expected_values.size() == 0) begin
         $display("binomial_mod_prime_unit_tb passed");
      end else begin
         $display("binomial_mod_prime_unit_tb failed");
      end
      $finish;
   end

   // Bound the run well past the slowest legal schedule
   initial begin
      #60000000;
      $display("binomial_mod_prime_unit_tb failed");
      $finish;
   end

endmodule
